// ===== rtl/spiral_order_matrix_reader_macros.svh =====
// Assertion macros used by the spiral reader checker.
`ifndef SPIRAL_ORDER_MATRIX_READER_MACROS_SVH
`define SPIRAL_ORDER_MATRIX_READER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SOMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SOMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/somr_pkg.sv =====
// Types and constants shared by the spiral-order matrix reader.
`default_nettype none
package somr_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIM_W     = 5;
  localparam int unsigned CNT_W     = 2 * DIM_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_FETCH = 1'b1
  } cmd_e_t;

  typedef struct packed {
    cmd_e_t                   command;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic                     last_of_matrix;
    logic                     nothing_left;
  } out_item_t;

  typedef struct packed {
    logic load_wr;
    logic restart;
    logic fetch_go;
    logic show_empty;
  } somr_cmd_t;

  typedef struct packed {
    logic all_loaded;
    logic all_emitted;
  } somr_stat_t;

endpackage
`default_nettype wire

// ===== rtl/somr_ctrl.sv =====
// Command decode and result sequencing for the spiral reader.
`default_nettype none
module somr_ctrl
  import somr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  cmd_e_t     in_command,
  input  somr_stat_t stat,
  output logic       busy,
  output logic       out_valid,
  output somr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EMIT  = 3'b010,
    S_EMPTY = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;
  logic   is_load;
  logic   is_fetch;
  logic   restart;
  logic   fetch_ok;

  assign busy     = !rst_n;
  assign accept   = start && !busy;
  assign is_load  = accept && (in_command == CMD_LOAD);
  assign is_fetch = accept && (in_command == CMD_FETCH);
  assign restart  = is_load && stat.all_loaded && stat.all_emitted;
  assign fetch_ok = stat.all_loaded && !stat.all_emitted;

  assign cmd.restart    = restart;
  assign cmd.load_wr    = is_load && (restart || !stat.all_loaded);
  assign cmd.fetch_go   = is_fetch && fetch_ok;
  assign cmd.show_empty = (state_r == S_EMPTY);

  always_comb begin
    state_nxt = S_IDLE;
    if (is_fetch) begin
      state_nxt = fetch_ok ? S_EMIT : S_EMPTY;
    end
  end

  always_comb begin
    unique case (state_r) inside
      S_IDLE:         out_valid = 1'b0;
      S_EMIT, S_EMPTY: out_valid = 1'b1;
      default:        out_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/somr_datapath.sv =====
// Element store, counters, spiral walk and result register.
`default_nettype none
module somr_datapath
  import somr_pkg::*;
#(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [DIM_W-1:0]         cfg_wdata,
  input  logic signed [DATA_W-1:0] load_value,
  input  somr_cmd_t                cmd,
  output somr_stat_t               stat,
  output out_item_t                out_item
);

  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned DIM_CAP = (MAX_DIM < 31) ? MAX_DIM : 31;
  localparam int unsigned SW      = CNT_W + 2;
  localparam int unsigned IDX_W   = CNT_W + DIM_W + 1;
  localparam logic [DIM_W-1:0]    DIM_MAX = DIM_W'(DIM_CAP);
  localparam logic [IDX_W-1:0]    DEPTH_V = IDX_W'(DEPTH);
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);

  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_BOTTOM = 2'd2,
    SIDE_LEFT   = 2'd3
  } side_t;

  logic [DIM_W-1:0]  rows_r, cols_r;
  logic [DIM_W-1:0]  nr, nc;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [CNT_W-1:0]  emitted_r, emitted_nxt;
  logic [CNT_W-1:0]  ring_r, ring_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  side_t             side_r, side_nxt;
  logic [CNT_W-1:0]  ring_inc;

  logic signed [SW-1:0] k_s, row_s, col_s, bottom_s, right_s;

  logic [IDX_W-1:0]  rd_idx;
  logic              rd_ok;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;
  logic              rd_ok_r;
  logic              last_r;

  // effective dimensions: zero reads as one, clamp to the store size
  assign nr = (rows_r == '0) ? DIM_W'(1) : ((rows_r > DIM_MAX) ? DIM_MAX : rows_r);
  assign nc = (cols_r == '0) ? DIM_W'(1) : ((cols_r > DIM_MAX) ? DIM_MAX : cols_r);
  assign total = {{DIM_W{1'b0}}, nr} * {{DIM_W{1'b0}}, nc};

  assign stat.all_loaded  = (loaded_r >= total);
  assign stat.all_emitted = (emitted_r >= total);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= DIM_W'(1);
      cols_r <= DIM_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROWS: rows_r <= cfg_wdata;
        REG_COLS: cols_r <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // ring bounds, signed since inner bounds can cross
  assign k_s      = signed'({2'b00, ring_r});
  assign row_s    = signed'({2'b00, row_r});
  assign col_s    = signed'({2'b00, col_r});
  assign bottom_s = signed'({{(SW-DIM_W){1'b0}}, nr}) - ONE_S - k_s;
  assign right_s  = signed'({{(SW-DIM_W){1'b0}}, nc}) - ONE_S - k_s;
  assign ring_inc = ring_r + CNT_W'(1);

  always_comb begin
    ring_nxt = ring_r;
    side_nxt = side_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    if (cmd.restart) begin
      ring_nxt = '0;
      side_nxt = SIDE_TOP;
      row_nxt  = '0;
      col_nxt  = '0;
    end else if (cmd.fetch_go) begin
      unique case (side_r)
        SIDE_TOP: begin
          if (col_s < right_s) begin
            col_nxt = col_r + CNT_W'(1);
          end else if (row_s < bottom_s) begin
            side_nxt = SIDE_RIGHT;
            row_nxt  = row_r + CNT_W'(1);
          end else begin
            ring_nxt = ring_inc;
            side_nxt = SIDE_TOP;
            row_nxt  = ring_inc;
            col_nxt  = ring_inc;
          end
        end
        SIDE_RIGHT: begin
          if (row_s < bottom_s) begin
            row_nxt = row_r + CNT_W'(1);
          end else if (col_s > k_s) begin
            side_nxt = SIDE_BOTTOM;
            col_nxt  = col_r - CNT_W'(1);
          end else begin
            ring_nxt = ring_inc;
            side_nxt = SIDE_TOP;
            row_nxt  = ring_inc;
            col_nxt  = ring_inc;
          end
        end
        SIDE_BOTTOM: begin
          if (col_s > k_s) begin
            col_nxt = col_r - CNT_W'(1);
          end else if (row_s - ONE_S > k_s) begin
            side_nxt = SIDE_LEFT;
            row_nxt  = row_r - CNT_W'(1);
          end else begin
            ring_nxt = ring_inc;
            side_nxt = SIDE_TOP;
            row_nxt  = ring_inc;
            col_nxt  = ring_inc;
          end
        end
        SIDE_LEFT: begin
          if (row_s > k_s + ONE_S) begin
            row_nxt = row_r - CNT_W'(1);
          end else begin
            ring_nxt = ring_inc;
            side_nxt = SIDE_TOP;
            row_nxt  = ring_inc;
            col_nxt  = ring_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    loaded_nxt  = loaded_r;
    emitted_nxt = emitted_r;
    if (cmd.restart) begin
      loaded_nxt  = CNT_W'(1);
      emitted_nxt = '0;
    end else begin
      if (cmd.load_wr) begin
        loaded_nxt = loaded_r + CNT_W'(1);
      end
      if (cmd.fetch_go) begin
        emitted_nxt = emitted_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= '0;
      emitted_r <= '0;
      ring_r    <= '0;
      side_r    <= SIDE_TOP;
      row_r     <= '0;
      col_r     <= '0;
    end else begin
      loaded_r  <= loaded_nxt;
      emitted_r <= emitted_nxt;
      ring_r    <= ring_nxt;
      side_r    <= side_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
    end
  end

  // row-major store index of the walk position
  assign rd_idx = IDX_W'(row_r) * IDX_W'(nc) + IDX_W'(col_r);
  assign rd_ok  = (rd_idx < DEPTH_V);

  assign wr_idx = cmd.restart ? '0 : IDX_W'(loaded_r);
  assign wr_en  = cmd.load_wr && (wr_idx < DEPTH_V);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_idx[AW-1:0]] <= load_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch_go) begin
      rd_data_r <= mem_r[rd_idx[AW-1:0]];
      rd_ok_r   <= rd_ok;
      last_r    <= ((emitted_r + CNT_W'(1)) == total);
    end
  end

  always_comb begin
    out_item.nothing_left   = cmd.show_empty;
    out_item.last_of_matrix = cmd.show_empty ? 1'b0 : last_r;
    out_item.element        = (cmd.show_empty || !rd_ok_r) ? '0 : signed'(rd_data_r);
  end

endmodule
`default_nettype wire

// ===== rtl/spiral_order_matrix_reader.sv =====
// Spiral-order matrix reader: row-major load, clockwise spiral fetch.
// Load: no result. Fetch: result strobe in the cycle after start.
// Throughput: one command per cycle; busy is low outside reset.
// The fetch path is one store read, registered, plus one walk step.
// Reset (sync, rst_n low): counts and walk clear, rows = cols = 1.
// Store contents are not cleared; entries are written by loads only.
`default_nettype none
module spiral_order_matrix_reader
  import somr_pkg::*;
#(
  parameter int unsigned MAX_DIM = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  somr_cmd_t  cmd;
  somr_stat_t stat;

  assign cfg_ready = rst_n;

  somr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_data.command),
    .stat       (stat),
    .busy       (busy),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  somr_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_idx    (cfg_index),
    .cfg_wdata  (cfg_data),
    .load_value (in_data.value),
    .cmd        (cmd),
    .stat       (stat),
    .out_item   (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/somr_checker.sv =====
// Port-level checks for the spiral reader, bound to the top level.
`default_nettype none
`include "spiral_order_matrix_reader_macros.svh"
module somr_checker
  import somr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  logic fetch_beat;

  assign fetch_beat = start && !busy && (in_data.command == CMD_FETCH);

  // every fetch beat yields a result beat in the next cycle
  `SOMR_ASSERT_NEXT(a_fetch_gives_result, fetch_beat, out_valid, "fetch without result")

  // a result beat only follows a fetch beat
  `SOMR_ASSERT_NOW(a_result_from_fetch, out_valid, $past(fetch_beat), "result without fetch")

  // empty result carries no element and no last flag
  `SOMR_ASSERT_NOW(a_empty_is_clean, out_valid && out_data.nothing_left,
    (out_data.element == '0) && !out_data.last_of_matrix, "empty result not clean")

endmodule

bind spiral_order_matrix_reader somr_checker u_somr_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the spiral-order matrix reader: directed rows, then random beats.
`timescale 1ns / 1ps
module testbench;
  import somr_pkg::*;

  localparam int MAX_DIM = 16;
  localparam int STORE_WORDS = MAX_DIM * MAX_DIM;
  localparam int ITEMS = 1200;
  localparam int SETTLE = 4;
  localparam int LIMIT = 200000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef enum int {TOP_ROW, RIGHT_COL, BOTTOM_ROW, LEFT_COL} side_e;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     dim;
    cmd_e_t               cmd;
    logic [DATA_W-1:0]    val;
    bit                   pin;
    out_item_t            want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  // predictor state
  logic [DIM_W-1:0]  dim_rows, dim_cols;
  logic [DATA_W-1:0] store_words [STORE_WORDS];
  int unsigned       n_loaded, n_emitted;
  int                ring, w_row, w_col;
  side_e             side;

  out_item_t due_words[$];
  int        mismatches;
  int        counted_items;
  int        cycles;
  int        burst_left;

  spiral_order_matrix_reader #(.MAX_DIM(MAX_DIM)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_dim(logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > MAX_DIM) return MAX_DIM;
    return int'(d);
  endfunction

  function automatic void begin_ring(int k);
    ring  = k;
    side  = TOP_ROW;
    w_row = k;
    w_col = k;
  endfunction

  function automatic void step_spiral(input in_item_t it, output bit got, output out_item_t r);
    int          nr, nc, top, left, bottom, right;
    int unsigned total, idx;
    logic [DATA_W-1:0] word;
    nr    = eff_dim(dim_rows);
    nc    = eff_dim(dim_cols);
    total = nr * nc;
    got   = 1'b0;
    r     = '0;
    if (it.command == CMD_LOAD) begin
      if (n_loaded >= total && n_emitted >= total) begin
        n_loaded  = 0;
        n_emitted = 0;
        begin_ring(0);
      end
      if (n_loaded < total) begin
        store_words[n_loaded] = it.value;
        n_loaded++;
        counted_items++;
      end
      return;
    end
    counted_items++;
    got = 1'b1;
    if (n_loaded < total || n_emitted >= total) begin
      r.nothing_left = 1'b1;
      return;
    end
    word = '0;
    if (w_row >= 0 && w_col >= 0) begin
      idx = w_row * nc + w_col;
      if (idx < STORE_WORDS) word = store_words[idx];
    end
    n_emitted++;
    r.element        = word;
    r.last_of_matrix = (n_emitted == total);
    top    = ring;
    left   = ring;
    bottom = nr - 1 - ring;
    right  = nc - 1 - ring;
    case (side)
      TOP_ROW: begin
        if (w_col < right) w_col++;
        else if (w_row < bottom) begin
          side = RIGHT_COL;
          w_row++;
        end else begin_ring(ring + 1);
      end
      RIGHT_COL: begin
        if (w_row < bottom) w_row++;
        else if (w_col > left) begin
          side = BOTTOM_ROW;
          w_col--;
        end else begin_ring(ring + 1);
      end
      BOTTOM_ROW: begin
        if (w_col > left) w_col--;
        else if (w_row - 1 > top) begin
          side = LEFT_COL;
          w_row--;
        end else begin_ring(ring + 1);
      end
      default: begin
        if (w_row > top + 1) w_row--;
        else begin_ring(ring + 1);
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return DIM_W'($urandom_range(17, 31));
      1: return '0;
      2: return DIM_W'($urandom_range(6, 16));
      default: return DIM_W'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic plan_row_t row_load(logic [DATA_W-1:0] v);
    plan_row_t p;
    p     = '{cmd: CMD_LOAD, default: '0};
    p.cmd = CMD_LOAD;
    p.val = v;
    return p;
  endfunction

  function automatic plan_row_t row_fetch();
    plan_row_t p;
    p     = '{cmd: CMD_LOAD, default: '0};
    p.cmd = CMD_FETCH;
    p.val = $urandom;
    return p;
  endfunction

  function automatic plan_row_t row_fetch_is(logic [DATA_W-1:0] e, logic l, logic n);
    plan_row_t p;
    p                     = row_fetch();
    p.pin                 = 1'b1;
    p.want.element        = e;
    p.want.last_of_matrix = l;
    p.want.nothing_left   = n;
    return p;
  endfunction

  function automatic plan_row_t row_cfg(logic [CFG_IDX_W-1:0] i, logic [DIM_W-1:0] d);
    plan_row_t p;
    p        = '{cmd: CMD_LOAD, default: '0};
    p.cmd    = CMD_LOAD;
    p.is_cfg = 1'b1;
    p.idx    = i;
    p.dim    = d;
    return p;
  endfunction

  // entered and left at a falling edge
  task automatic pace();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  task automatic issue(cmd_e_t c, logic [DATA_W-1:0] v, bit pin, out_item_t want);
    in_item_t  it;
    bit        got;
    out_item_t r;
    it.command = c;
    it.value   = v;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    step_spiral(it, got, r);
    if (got) due_words.push_back(pin ? want : r);
    @(negedge clk);
    pace();
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (due_words.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Dimension writes land only where no later fetch can reach a stale walk
  // or an unwritten word: before the first fetch of a matrix, or after
  // read-out when the matrix does not grow. Otherwise read out / restart first.
  task automatic write_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] d);
    int unsigned cur, nxt;
    cur = eff_dim(dim_rows) * eff_dim(dim_cols);
    if (idx == REG_ROWS) nxt = eff_dim(d) * eff_dim(dim_cols);
    else if (idx == REG_COLS) nxt = eff_dim(dim_rows) * eff_dim(d);
    else nxt = cur;
    if (n_emitted != 0 && !(n_loaded >= cur && n_emitted >= cur && nxt <= cur)) begin
      while (n_emitted < cur) issue(CMD_FETCH, $urandom, 1'b0, '0);
      if (nxt > cur) issue(CMD_LOAD, rand_word(), 1'b0, '0);
    end
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_ROWS) dim_rows = d;
    else if (idx == REG_COLS) dim_cols = d;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (due_words.size() == 0) begin
        mismatches++;
        $display("%0t: result with none due, got %h", $time, out_data);
      end else begin
        want = due_words.pop_front();
        if (out_data.element !== want.element) begin
          mismatches++;
          $display("%0t: element exp %h got %h", $time, want.element, out_data.element);
        end
        if (out_data.last_of_matrix !== want.last_of_matrix) begin
          mismatches++;
          $display("%0t: last_of_matrix exp %b got %b", $time, want.last_of_matrix,
                   out_data.last_of_matrix);
        end
        if (out_data.nothing_left !== want.nothing_left) begin
          mismatches++;
          $display("%0t: nothing_left exp %b got %b", $time, want.nothing_left,
                   out_data.nothing_left);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** spiral_order_matrix_reader: FAILED **");
      $finish;
    end
  end

  initial begin
    plan_row_t   plan[$];
    int unsigned tot;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROWS;
    cfg_data  = '0;
    mismatches    = 0;
    counted_items = 0;
    cycles        = 0;
    burst_left    = $urandom_range(1, 8);
    dim_rows  = 5'd1;
    dim_cols  = 5'd1;
    n_loaded  = 0;
    n_emitted = 0;
    begin_ring(0);
    foreach (store_words[i]) store_words[i] = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // 1x1 after reset: empty fetch, read-out, late fetch, new matrix, extra load
    plan.push_back(row_fetch_is(32'h0, 1'b0, 1'b1));
    plan.push_back(row_load(32'h8000_0000));
    plan.push_back(row_fetch_is(32'h8000_0000, 1'b1, 1'b0));
    plan.push_back(row_fetch_is(32'h0, 1'b0, 1'b1));
    plan.push_back(row_load(32'h7FFF_FFFF));
    plan.push_back(row_load(32'h0000_0005));
    plan.push_back(row_fetch_is(32'h7FFF_FFFF, 1'b1, 1'b0));
    plan.push_back(row_cfg(CFG_IDX_SPARE, 5'd9));
    // grow to 2x3 after the first load of a matrix
    plan.push_back(row_load(32'hFFFF_FFFF));
    plan.push_back(row_cfg(REG_ROWS, 5'd2));
    plan.push_back(row_cfg(REG_COLS, 5'd3));
    for (int i = 0; i < 5; i++) plan.push_back(row_load(i));
    for (int i = 0; i < 6; i++) plan.push_back(row_fetch());
    // rows 0 acts as 1: 1x2, late fetch, new matrix, early fetch
    plan.push_back(row_cfg(REG_ROWS, 5'd0));
    plan.push_back(row_cfg(REG_COLS, 5'd2));
    plan.push_back(row_fetch_is(32'h0, 1'b0, 1'b1));
    plan.push_back(row_load(32'h1234_5678));
    plan.push_back(row_fetch_is(32'h0, 1'b0, 1'b1));
    plan.push_back(row_load(32'hA5A5_5A5A));
    plan.push_back(row_fetch());
    plan.push_back(row_fetch());

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_dim(plan[i].idx, plan[i].dim);
      else issue(plan[i].cmd, plan[i].val, plan[i].pin, plan[i].want);
    end

    while (counted_items < ITEMS) begin
      if ($urandom_range(0, 3) != 0) write_dim(REG_ROWS, pick_dim());
      if ($urandom_range(0, 3) != 0) write_dim(REG_COLS, pick_dim());
      tot = eff_dim(dim_rows) * eff_dim(dim_cols);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(4, 24))
          issue(cmd_e_t'($urandom_range(0, 1)), rand_word(), 1'b0, '0);
      end else begin
        do begin
          if ($urandom_range(0, 9) == 0) issue(CMD_FETCH, $urandom, 1'b0, '0);
          issue(CMD_LOAD, rand_word(), 1'b0, '0);
          if ($urandom_range(0, 39) == 0) begin
            write_dim($urandom_range(0, 1) ? REG_ROWS : REG_COLS, pick_dim());
            tot = eff_dim(dim_rows) * eff_dim(dim_cols);
          end
        end while (n_loaded < tot);
        while (n_loaded >= tot && n_emitted < tot) begin
          if ($urandom_range(0, 9) == 0) issue(CMD_LOAD, rand_word(), 1'b0, '0);
          issue(CMD_FETCH, $urandom, 1'b0, '0);
        end
        if ($urandom_range(0, 2) == 0) issue(CMD_FETCH, $urandom, 1'b0, '0);
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("** spiral_order_matrix_reader: PASSED **");
    end else begin
      $display("** spiral_order_matrix_reader: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/somr_pkg.sv
rtl/somr_ctrl.sv
rtl/somr_datapath.sv
rtl/spiral_order_matrix_reader.sv
rtl/somr_checker.sv
sim/testbench.sv
